// ===== src/lex_order_partition_refine_unit_defines.svh =====
// Assertion macros for the lexicographic ordering unit.
`ifndef LEX_ORDER_PARTITION_REFINE_UNIT_DEFINES_SVH
`define LEX_ORDER_PARTITION_REFINE_UNIT_DEFINES_SVH
// same-cycle implication
`define LOP_CHECK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define LOP_CHECK_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== src/lop_pkg.sv =====
// Shared types and constants for the lexicographic ordering unit.
`default_nettype none
package lop_pkg;
	localparam int DEF_MAX_COLS = 1024;
	localparam int DEF_ROW_BITS = 32;
	localparam int COL_W = 10;
	localparam int NC_W = 11;
	localparam int STAT_W = 2;

	localparam logic [STAT_W-1:0] ERR_OK = 2'd0;
	localparam logic [STAT_W-1:0] ERR_TAIL = 2'd1;
	localparam logic [STAT_W-1:0] ERR_NOID = 2'd2;
	localparam logic [STAT_W-1:0] ERR_INCOMPLETE = 2'd3;

	typedef enum logic [1:0] {
		OP_INIT,
		OP_ENTRY,
		OP_FIN,
		OP_READ
	} op_t;

	typedef enum logic [5:0] {
		ST_IDLE, ST_CLR, ST_OUT, ST_RD,
		ST_E_C, ST_E_S,
		ST_SP_N1, ST_SP_P0, ST_SP_P1, ST_SP_A, ST_SP_Q0, ST_SP_Q1, ST_SP_W,
		ST_J_K, ST_J_P0, ST_J_P1, ST_J_N0, ST_J_N1, ST_J_S,
		ST_J_X0, ST_J_X1, ST_J_Y0, ST_J_Y1,
		ST_J_T0, ST_J_T1, ST_J_T2, ST_J_T3,
		ST_F_LOOP, ST_F_TL, ST_F_B, ST_F_B1, ST_F_W, ST_F_W1, ST_F_END
	} state_t;
endpackage
`default_nettype wire

// ===== src/lop_req_if.sv =====
// Request channel: op beats into the ordering unit.
`default_nettype none
interface lop_req_if import lop_pkg::*; ();
	logic valid;
	logic ready;
	op_t op;
	logic [COL_W-1:0] col;
	logic new_row;
	logic [COL_W-1:0] position;

	modport source(output valid, op, col, new_row, position, input ready);
	modport sink(input valid, op, col, new_row, position, output ready);
endinterface
`default_nettype wire

// ===== src/lop_rsp_if.sv =====
// Response channel: result beats out of the ordering unit.
`default_nettype none
interface lop_rsp_if import lop_pkg::*; ();
	logic valid;
	logic ready;
	logic [COL_W-1:0] out_col;
	logic [STAT_W-1:0] status;

	modport source(output valid, out_col, status, input ready);
	modport sink(input valid, out_col, status, output ready);
endinterface
`default_nettype wire

// ===== src/lop_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lop_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== src/lex_order_partition_refine_unit.sv =====
// Lexicographic column ordering unit. Its tables sit in single-port-read RAMs (column links,
// set records, free id stack, order store) driven by one sequencer, one RAM access per
// memory per cycle, so one beat is in work at a time. After reset and on each init op the
// unit sweeps MAX_COLS+2 entries, one per cycle, with req.ready low (num_cols writes are still
// taken). An entry op is ignored, touches a singleton set, splits a set or moves a column into
// another set; finalize walks every set and every column, and a read looks up the order store.
// Results leave through an output register, so the next request is taken while a response
// still waits.
`default_nettype none
`include "lex_order_partition_refine_unit_defines.svh"
module lex_order_partition_refine_unit import lop_pkg::*; #(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int ROW_BITS = DEF_ROW_BITS
) (
	input logic clk,
	input logic arst_n,
	lop_req_if.sink req,
	lop_rsp_if.source rsp,
	input logic cfg_we,
	input logic [NC_W-1:0] cfg_wdata
);
	localparam int SLOTS = MAX_COLS + 2;
	localparam int IW = $clog2(SLOTS);
	localparam int OW = $clog2(MAX_COLS);
	localparam int AW = (IW > NC_W) ? IW : NC_W;

	typedef struct packed {
		logic [IW-1:0] set;
		logic [IW-1:0] prev;
		logic [IW-1:0] nxt;
	} cword_t;

	typedef struct packed {
		logic [IW-1:0] size;
		logic [IW-1:0] tail;
		logic [IW-1:0] rep;
		logic [ROW_BITS-1:0] stamp;
		logic [IW-1:0] oprev;
		logic [IW-1:0] onext;
	} sword_t;

	function automatic logic [IW-1:0] ix(input logic [IW-1:0] v);
		return (int'(v) < SLOTS) ? v : '0;
	endfunction

	state_t state_q, state_d;
	logic [NC_W-1:0] num_cols_q;
	logic [IW-1:0] n_q, n_d, first_q, first_d, top_q, top_d, idx_q, idx_d;
	logic [ROW_BITS-1:0] row_q, row_d;
	logic [STAT_W-1:0] err_q, err_d;
	logic clr_rsp_q, clr_rsp_d, rd_ok_q, rd_ok_d;
	logic out_valid_q, out_load;
	logic [COL_W-1:0] out_col_q, res_col_q, res_col_d;
	logic [STAT_W-1:0] out_status_q;

	logic [IW-1:0] a_q, a_d, s_q, s_d, nid_q, nid_d, t_q, t_d, ttail_q, ttail_d;
	logic [IW-1:0] pos_q, pos_d, set_q, set_d, sets_q, sets_d;
	logic [IW-1:0] item_q, item_d, head_q, head_d, steps_q, steps_d;
	cword_t c_q, c_d;
	sword_t sr_q, sr_d;

	logic c_we, c_re, s_we, s_re, f_we, f_re, o_we, o_re;
	logic [IW-1:0] c_waddr, c_raddr, s_waddr, s_raddr, f_waddr, f_raddr, f_wdata, f_rdata;
	cword_t c_wdata, c_rdata;
	sword_t s_wdata, s_rdata;
	logic [OW-1:0] o_waddr, o_raddr;
	logic [COL_W-1:0] o_wdata, o_rdata;

	lop_ram #(.WIDTH($bits(cword_t)), .DEPTH(SLOTS)) u_col_ram (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.re(c_re), .raddr(c_raddr), .rdata(c_rdata)
	);
	lop_ram #(.WIDTH($bits(sword_t)), .DEPTH(SLOTS)) u_set_ram (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.re(s_re), .raddr(s_raddr), .rdata(s_rdata)
	);
	lop_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_free_ram (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.re(f_re), .raddr(f_raddr), .rdata(f_rdata)
	);
	lop_ram #(.WIDTH(COL_W), .DEPTH(MAX_COLS)) u_ord_ram (
		.clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
		.re(o_re), .raddr(o_raddr), .rdata(o_rdata)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.out_col = out_col_q;
	assign rsp.status = out_status_q;

	always_comb begin
		logic [AW-1:0] nc;
		logic [AW-1:0] a_full;
		logic [ROW_BITS-1:0] rinc;
		logic [IW-1:0] tnew;
		logic [IW-1:0] tj;
		nc = AW'(num_cols_q);
		a_full = AW'(req.col) + AW'(1);
		rinc = row_q + ROW_BITS'(1);
		tnew = (top_q != '0) ? top_q - IW'(1) : top_q;
		tj = ix(c_rdata.set);
		state_d = state_q;
		n_d = n_q;
		first_d = first_q;
		top_d = top_q;
		idx_d = idx_q;
		row_d = row_q;
		err_d = err_q;
		clr_rsp_d = clr_rsp_q;
		rd_ok_d = rd_ok_q;
		res_col_d = res_col_q;
		a_d = a_q;
		s_d = s_q;
		nid_d = nid_q;
		t_d = t_q;
		ttail_d = ttail_q;
		pos_d = pos_q;
		set_d = set_q;
		sets_d = sets_q;
		item_d = item_q;
		head_d = head_q;
		steps_d = steps_q;
		c_d = c_q;
		sr_d = sr_q;
		out_load = 1'b0;
		c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_re = 1'b0; c_raddr = '0;
		s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_re = 1'b0; s_raddr = '0;
		f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_re = 1'b0; f_raddr = '0;
		o_we = 1'b0; o_waddr = '0; o_wdata = '0; o_re = 1'b0; o_raddr = '0;
		case (state_q)
			ST_CLR: begin
				c_we = 1'b1;
				s_we = 1'b1;
				f_we = 1'b1;
				c_waddr = idx_q;
				s_waddr = idx_q;
				f_waddr = idx_q;
				if (idx_q != '0 && idx_q <= n_q) begin
					c_wdata.set = IW'(1);
					c_wdata.prev = idx_q - IW'(1);
					c_wdata.nxt = (idx_q == n_q) ? '0 : idx_q + IW'(1);
					f_wdata = idx_q + IW'(1);
				end
				if (idx_q == IW'(1)) begin
					s_wdata.size = n_q;
					s_wdata.tail = n_q;
					s_wdata.rep = IW'(1);
				end
				if (int'(idx_q) == SLOTS - 1) begin
					state_d = clr_rsp_q ? ST_OUT : ST_IDLE;
				end else begin
					idx_d = idx_q + IW'(1);
				end
			end
			ST_IDLE: begin
				if (req.valid) begin
					res_col_d = '0;
					case (req.op)
						OP_INIT: begin
							if (nc < AW'(2)) nc = AW'(2);
							if (nc > AW'(MAX_COLS)) nc = AW'(MAX_COLS);
							n_d = IW'(nc);
							first_d = IW'(1);
							top_d = IW'(1);
							row_d = '0;
							err_d = ERR_OK;
							idx_d = '0;
							clr_rsp_d = 1'b1;
							state_d = ST_CLR;
						end
						OP_ENTRY: begin
							if (req.new_row || row_q == '0) begin
								row_d = (rinc == '0) ? ROW_BITS'(1) : rinc;
							end
							if (err_q != ERR_OK || a_full > AW'(n_q)) begin
								state_d = ST_OUT;
							end else begin
								a_d = IW'(a_full);
								c_re = 1'b1;
								c_raddr = IW'(a_full);
								state_d = ST_E_C;
							end
						end
						OP_FIN: begin
							pos_d = '0;
							set_d = ix(first_q);
							sets_d = '0;
							state_d = ST_F_LOOP;
						end
						OP_READ: begin
							rd_ok_d = (AW'(req.position) < AW'(n_q)) &&
								(AW'(req.position) < AW'(MAX_COLS));
							o_re = 1'b1;
							o_raddr = OW'(req.position);
							state_d = ST_RD;
						end
						default: state_d = ST_OUT;
					endcase
				end
			end
			ST_RD: begin
				res_col_d = rd_ok_q ? o_rdata : '0;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_E_C: begin
				c_d = c_rdata;
				s_d = tj;
				s_re = 1'b1;
				s_raddr = tj;
				state_d = ST_E_S;
			end
			ST_E_S: begin
				sr_d = s_rdata;
				if (s_rdata.stamp != row_q) begin
					if (s_rdata.size == IW'(1) && s_rdata.tail != a_q) begin
						err_d = ERR_TAIL;
						state_d = ST_OUT;
					end else if (s_rdata.size > IW'(1)) begin
						if (top_q >= n_q + IW'(1)) begin
							err_d = ERR_NOID;
							state_d = ST_OUT;
						end else begin
							sr_d.stamp = row_q;
							if (s_rdata.tail == a_q) sr_d.tail = c_q.prev;
							sr_d.size = s_rdata.size - IW'(1);
							sr_d.rep = a_q;
							c_re = 1'b1;
							c_raddr = ix(c_q.prev);
							f_re = 1'b1;
							f_raddr = ix(top_q);
							state_d = ST_SP_N1;
						end
					end else begin
						s_we = 1'b1;
						s_waddr = s_q;
						s_wdata = s_rdata;
						s_wdata.stamp = row_q;
						s_wdata.rep = a_q;
						state_d = ST_OUT;
					end
				end else begin
					c_re = 1'b1;
					c_raddr = ix(s_rdata.rep);
					state_d = ST_J_K;
				end
			end
			ST_SP_N1: begin
				nid_d = ix(f_rdata);
				top_d = top_q + IW'(1);
				c_we = 1'b1;
				c_waddr = ix(c_q.prev);
				c_wdata = c_rdata;
				c_wdata.nxt = c_q.nxt;
				state_d = ST_SP_P0;
			end
			ST_SP_P0: begin
				c_re = 1'b1;
				c_raddr = ix(c_q.nxt);
				state_d = ST_SP_P1;
			end
			ST_SP_P1: begin
				c_we = 1'b1;
				c_waddr = ix(c_q.nxt);
				c_wdata = c_rdata;
				c_wdata.prev = c_q.prev;
				state_d = ST_SP_A;
			end
			ST_SP_A: begin
				c_we = 1'b1;
				c_waddr = a_q;
				c_wdata.set = nid_q;
				s_we = 1'b1;
				s_waddr = nid_q;
				s_wdata.size = IW'(1);
				s_wdata.tail = a_q;
				s_wdata.rep = a_q;
				s_wdata.stamp = row_q;
				s_wdata.oprev = sr_q.oprev;
				s_wdata.onext = s_q;
				state_d = (sr_q.oprev != '0) ? ST_SP_Q0 : ST_SP_W;
			end
			ST_SP_Q0: begin
				s_re = 1'b1;
				s_raddr = ix(sr_q.oprev);
				state_d = ST_SP_Q1;
			end
			ST_SP_Q1: begin
				s_we = 1'b1;
				s_waddr = ix(sr_q.oprev);
				s_wdata = s_rdata;
				s_wdata.onext = nid_q;
				state_d = ST_SP_W;
			end
			ST_SP_W: begin
				s_we = 1'b1;
				s_waddr = s_q;
				s_wdata = sr_q;
				s_wdata.oprev = nid_q;
				if (first_q == s_q) first_d = nid_q;
				state_d = ST_OUT;
			end
			ST_J_K: begin
				t_d = tj;
				if (tj == '0 || (tj == s_q && sr_q.size < IW'(2))) begin
					state_d = ST_OUT;
				end else begin
					c_we = 1'b1;
					c_waddr = a_q;
					c_wdata = c_q;
					c_wdata.set = tj;
					if (sr_q.tail == a_q) sr_d.tail = c_q.prev;
					sr_d.size = sr_q.size - IW'(1);
					state_d = ST_J_P0;
				end
			end
			ST_J_P0: begin
				c_re = 1'b1;
				c_raddr = ix(c_q.prev);
				state_d = ST_J_P1;
			end
			ST_J_P1: begin
				c_we = 1'b1;
				c_waddr = ix(c_q.prev);
				c_wdata = c_rdata;
				c_wdata.nxt = c_q.nxt;
				state_d = ST_J_N0;
			end
			ST_J_N0: begin
				c_re = 1'b1;
				c_raddr = ix(c_q.nxt);
				state_d = ST_J_N1;
			end
			ST_J_N1: begin
				c_we = 1'b1;
				c_waddr = ix(c_q.nxt);
				c_wdata = c_rdata;
				c_wdata.prev = c_q.prev;
				state_d = ST_J_S;
			end
			ST_J_S: begin
				s_we = 1'b1;
				s_waddr = s_q;
				if (sr_q.size == '0) begin
					top_d = tnew;
					f_we = 1'b1;
					f_waddr = ix(tnew);
					f_wdata = s_q;
					if (first_q == s_q) first_d = sr_q.onext;
					if (sr_q.onext != '0) state_d = ST_J_X0;
					else if (sr_q.oprev != '0) state_d = ST_J_Y0;
					else state_d = ST_J_T0;
				end else begin
					s_wdata = sr_q;
					state_d = ST_J_T0;
				end
			end
			ST_J_X0: begin
				s_re = 1'b1;
				s_raddr = ix(sr_q.onext);
				state_d = ST_J_X1;
			end
			ST_J_X1: begin
				s_we = 1'b1;
				s_waddr = ix(sr_q.onext);
				s_wdata = s_rdata;
				s_wdata.oprev = sr_q.oprev;
				state_d = (sr_q.oprev != '0) ? ST_J_Y0 : ST_J_T0;
			end
			ST_J_Y0: begin
				s_re = 1'b1;
				s_raddr = ix(sr_q.oprev);
				state_d = ST_J_Y1;
			end
			ST_J_Y1: begin
				s_we = 1'b1;
				s_waddr = ix(sr_q.oprev);
				s_wdata = s_rdata;
				s_wdata.onext = sr_q.onext;
				state_d = ST_J_T0;
			end
			ST_J_T0: begin
				s_re = 1'b1;
				s_raddr = t_q;
				state_d = ST_J_T1;
			end
			ST_J_T1: begin
				ttail_d = s_rdata.tail;
				c_we = 1'b1;
				c_waddr = a_q;
				c_wdata.set = t_q;
				c_wdata.prev = s_rdata.tail;
				s_we = 1'b1;
				s_waddr = t_q;
				s_wdata = s_rdata;
				s_wdata.tail = a_q;
				s_wdata.size = s_rdata.size + IW'(1);
				state_d = ST_J_T2;
			end
			ST_J_T2: begin
				c_re = 1'b1;
				c_raddr = ix(ttail_q);
				state_d = ST_J_T3;
			end
			ST_J_T3: begin
				c_we = 1'b1;
				c_waddr = ix(ttail_q);
				c_wdata = c_rdata;
				c_wdata.nxt = a_q;
				state_d = ST_OUT;
			end
			ST_F_LOOP: begin
				if (set_q == '0 || sets_q >= n_q) begin
					state_d = ST_F_END;
				end else begin
					sets_d = sets_q + IW'(1);
					s_re = 1'b1;
					s_raddr = set_q;
					state_d = ST_F_TL;
				end
			end
			ST_F_TL: begin
				sr_d = s_rdata;
				item_d = ix(s_rdata.tail);
				head_d = '0;
				steps_d = '0;
				state_d = ST_F_B;
			end
			ST_F_B: begin
				if (item_q != '0 && steps_q <= n_q) begin
					head_d = item_q;
					steps_d = steps_q + IW'(1);
					c_re = 1'b1;
					c_raddr = item_q;
					state_d = ST_F_B1;
				end else begin
					steps_d = '0;
					state_d = ST_F_W;
				end
			end
			ST_F_B1: begin
				item_d = ix(c_rdata.prev);
				state_d = ST_F_B;
			end
			ST_F_W: begin
				if (head_q != '0 && steps_q <= n_q) begin
					if (pos_q < n_q) begin
						o_we = 1'b1;
						o_waddr = OW'(pos_q);
						o_wdata = COL_W'(head_q - IW'(1));
					end
					if (pos_q <= n_q) pos_d = pos_q + IW'(1);
					steps_d = steps_q + IW'(1);
					c_re = 1'b1;
					c_raddr = head_q;
					state_d = ST_F_W1;
				end else begin
					set_d = ix(sr_q.onext);
					state_d = ST_F_LOOP;
				end
			end
			ST_F_W1: begin
				head_d = ix(c_rdata.nxt);
				state_d = ST_F_W;
			end
			ST_F_END: begin
				if (pos_q != n_q && err_q == ERR_OK) err_d = ERR_INCOMPLETE;
				state_d = ST_OUT;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cols_q <= NC_W'(2);
			n_q <= IW'(2);
			first_q <= IW'(1);
			top_q <= IW'(1);
			idx_q <= '0;
			row_q <= '0;
			err_q <= ERR_OK;
			clr_rsp_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) num_cols_q <= cfg_wdata;
			n_q <= n_d;
			first_q <= first_d;
			top_q <= top_d;
			idx_q <= idx_d;
			row_q <= row_d;
			err_q <= err_d;
			clr_rsp_q <= clr_rsp_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_ok_q <= rd_ok_d;
		res_col_q <= res_col_d;
		a_q <= a_d;
		s_q <= s_d;
		nid_q <= nid_d;
		t_q <= t_d;
		ttail_q <= ttail_d;
		pos_q <= pos_d;
		set_q <= set_d;
		sets_q <= sets_d;
		item_q <= item_d;
		head_q <= head_d;
		steps_q <= steps_d;
		c_q <= c_d;
		sr_q <= sr_d;
		if (out_load) begin
			out_col_q <= res_col_q;
			out_status_q <= err_q;
		end
	end

	`LOP_CHECK_NOW(a_col_rw, c_we && c_re, c_waddr != c_raddr, "column RAM read/write collide")
	`LOP_CHECK_NOW(a_set_rw, s_we && s_re, s_waddr != s_raddr, "set RAM read/write collide")
	`LOP_CHECK_NOW(a_top_bound, state_q == ST_IDLE, top_q <= n_q + IW'(1), "free stack overrun")
	`LOP_CHECK_NOW(a_pos_bound, state_q == ST_F_END, pos_q <= n_q + IW'(1), "order position overrun")
	`LOP_CHECK_NXT(a_err_sticky,
		err_q != ERR_OK && !(state_q == ST_IDLE && req.valid && req.op == OP_INIT),
		err_q == $past(err_q), "error code changed without init")
endmodule
`default_nettype wire
